// ===== rtl/wavetable_oscillator_bank_defines.svh =====
// ---------------------------------------------------------------------------
// Wavetable oscillator bank assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_BANK_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_BANK_DEFINES_SVH

// same-cycle implication
`define WOB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wob check failed");

// next-cycle implication
`define WOB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wob check failed");

`endif

// ===== rtl/wob_pkg.sv =====
// ---------------------------------------------------------------------------
// wob_pkg
// Shared constants, command codes and helper functions of the oscillator bank.
// ---------------------------------------------------------------------------
package wob_pkg;

	localparam int NUM_OSC   = 32;
	localparam int OSC_W     = $clog2(NUM_OSC);
	localparam int CNT_W     = OSC_W + 1;
	localparam int RAM_BYTES = 65536;
	localparam int RAM_AW    = $clog2(RAM_BYTES);

	// request kinds
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_RAM   = 2'd3;

	// register banks, selected by address bits 7..5
	localparam logic [2:0] BANK_FLO  = 3'd0;
	localparam logic [2:0] BANK_FHI  = 3'd1;
	localparam logic [2:0] BANK_VOL  = 3'd2;
	localparam logic [2:0] BANK_DATA = 3'd3;
	localparam logic [2:0] BANK_PTR  = 3'd4;
	localparam logic [2:0] BANK_CTRL = 3'd5;
	localparam logic [2:0] BANK_WAVE = 3'd6;
	localparam logic [2:0] BANK_MISC = 3'd7;

	localparam logic [7:0] ADDR_IRQ   = 8'hE0;
	localparam logic [7:0] IRQ_ANSWER = 8'h41;
	localparam logic [7:0] IRQ_MARK   = 8'h80;
	localparam logic [7:0] SILENCE    = 8'h80;
	localparam logic [1:0] MODE_FREE  = 2'd0;
	localparam logic [1:0] MODE_SYNC  = 2'd2;
	localparam logic [1:0] MODE_SWAP  = 2'd3;

	// datapath commands
	localparam logic [3:0] OP_IDLE = 4'd0;
	localparam logic [3:0] OP_CLR  = 4'd1;
	localparam logic [3:0] OP_CAP  = 4'd2;
	localparam logic [3:0] OP_TN   = 4'd3;
	localparam logic [3:0] OP_TRD  = 4'd4;
	localparam logic [3:0] OP_TAD  = 4'd5;
	localparam logic [3:0] OP_TMX  = 4'd6;
	localparam logic [3:0] OP_TPW  = 4'd7;
	localparam logic [3:0] OP_TFIN = 4'd8;
	localparam logic [3:0] OP_WR   = 4'd9;
	localparam logic [3:0] OP_RD   = 4'd10;
	localparam logic [3:0] OP_FIN  = 4'd11;

	typedef struct packed {
		logic [3:0] op;
		logic       adv;
	} wob_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic halted;
		logic osc_last;
		logic swap;
		logic out_free;
	} wob_stat_t;

	// table size minus one, also the index mask
	function automatic logic [16:0] size_m1(input logic [2:0] sz);
		size_m1 = (17'd256 << sz) - 17'd1;
	endfunction

	// table base mask
	function automatic logic [16:0] base_mask(input logic [2:0] sz);
		base_mask = 17'h1FF00 << sz;
	endfunction

endpackage

// ===== rtl/wob_ctrl.sv =====
// ---------------------------------------------------------------------------
// wob_ctrl
// Sequencer: clearing sweep, request dispatch and per-oscillator tick steps.
// ---------------------------------------------------------------------------
module wob_ctrl import wob_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [1:0] req_type,
	input  wob_stat_t stat,
	output wob_cmd_t  cmd
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_TN   = 4'd2;
	localparam logic [3:0] S_TRD  = 4'd3;
	localparam logic [3:0] S_TAD  = 4'd4;
	localparam logic [3:0] S_TMX  = 4'd5;
	localparam logic [3:0] S_TPW  = 4'd6;
	localparam logic [3:0] S_TFIN = 4'd7;
	localparam logic [3:0] S_WR   = 4'd8;
	localparam logic [3:0] S_RD   = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = OP_IDLE;
		cmd.adv = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_CAP;
					case (req_type)
						REQ_TICK:  state_d = S_TN;
						REQ_WRITE: state_d = S_WR;
						REQ_READ:  state_d = S_RD;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_TN: begin
				cmd.op  = OP_TN;
				state_d = S_TRD;
			end
			S_TRD: begin
				cmd.op  = OP_TRD;
				state_d = S_TAD;
			end
			S_TAD: begin
				cmd.op = OP_TAD;
				if (stat.halted) begin
					cmd.adv = 1'b1;
					state_d = stat.osc_last ? S_TFIN : S_TRD;
				end else begin
					state_d = S_TMX;
				end
			end
			S_TMX: begin
				cmd.op = OP_TMX;
				if (stat.swap) begin
					state_d = S_TPW;
				end else begin
					cmd.adv = 1'b1;
					state_d = stat.osc_last ? S_TFIN : S_TRD;
				end
			end
			S_TPW: begin
				cmd.op  = OP_TPW;
				cmd.adv = 1'b1;
				state_d = stat.osc_last ? S_TFIN : S_TRD;
			end
			S_TFIN: begin
				cmd.op  = OP_TFIN;
				state_d = S_FIN;
			end
			S_WR: begin
				cmd.op  = OP_WR;
				state_d = S_FIN;
			end
			S_RD: begin
				cmd.op  = OP_RD;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op = OP_FIN;
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLR;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/wob_datapath.sv =====
// ---------------------------------------------------------------------------
// wob_datapath
// Register banks, accumulators, sound RAM, mixer and result register.
// ---------------------------------------------------------------------------
module wob_datapath import wob_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  wob_cmd_t           cmd,
	output wob_stat_t          stat,
	input  logic [1:0]         req_type,
	input  logic [7:0]         reg_addr,
	input  logic [7:0]         reg_value,
	input  logic [15:0]        ram_addr,
	input  logic [7:0]         ram_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic [7:0]         read_data,
	output logic               irq_pending
);

	logic [3:0]          op;
	logic [RAM_AW-1:0]   clr_q;
	logic [3:0]          mv_q;
	logic [7:0]          addr_q, val_q;
	logic [OSC_W-1:0]    osc_q, rd_addr, part;
	logic [CNT_W-1:0]    n_q, n_now;
	logic [NUM_OSC-1:0]  pend_q;
	logic [7:0]          last_q;

	logic [7:0]          bank_a [8];
	logic [7:0]          ctrl_b, misc_b;
	logic                bwe [8];
	logic [OSC_W-1:0]    bwa [8];
	logic [7:0]          bwd [8];

	logic [31:0]         acc_mem [NUM_OSC];
	logic [31:0]         acc_rd;
	logic                awe;
	logic [OSC_W-1:0]    awa;
	logic [31:0]         awd;

	logic [7:0]          lfb_mem [NUM_OSC];
	logic [7:0]          lfb_rd;

	logic [7:0]          ram_mem [RAM_BYTES];
	logic [7:0]          ram_rd;
	logic [RAM_AW-1:0]   faddr;

	assign op   = cmd.op;
	assign part = osc_q ^ OSC_W'(1);
	assign rd_addr = (op == OP_CAP) ? ((req_type == REQ_TICK) ? '0 : reg_addr[OSC_W-1:0])
	                                : osc_q;

	// oscillator count from the count register
	always_comb begin
		n_now = {1'b0, misc_b[5:1]} + CNT_W'(1);
		if (n_now > CNT_W'(NUM_OSC)) n_now = CNT_W'(NUM_OSC);
	end

	// ---- fetch address and end test ----
	logic [7:0]  c_now, w_now;
	logic [2:0]  sz;
	logic [4:0]  shift;
	logic [31:0] pos;
	logic [16:0] tm1, idx, base, sum;
	assign c_now = bank_a[BANK_CTRL];
	assign w_now = bank_a[BANK_WAVE];
	assign sz    = w_now[5:3];
	assign shift = 5'd9 + {2'b00, w_now[2:0]} - {2'b00, sz};
	assign pos   = acc_rd >> shift;
	assign tm1   = size_m1(sz);
	assign idx   = pos[16:0] & tm1;
	assign base  = {1'b0, bank_a[BANK_PTR], 8'h00} & base_mask(sz);
	assign sum   = idx + base;
	assign faddr = sum[RAM_AW-1:0];

	logic [31:0] acc_new_q, wrap_q;
	logic        end_q;

	always_ff @(posedge clk) begin
		if (op == OP_TAD) begin
			acc_new_q <= acc_rd + {16'h0000, bank_a[BANK_FHI], bank_a[BANK_FLO]};
			wrap_q    <= {15'h0000, tm1} << shift;
			end_q     <= (pos >= {15'h0000, tm1});
		end
	end

	// ---- end of wave and mix term ----
	logic              zero, eow;
	logic [1:0]        mode, pmode;
	logic [7:0]        c2;
	logic [31:0]       acc2;
	logic signed [8:0] diff;
	logic signed [17:0] prod;
	logic signed [21:0] mix_q;

	assign zero  = (ram_rd == 8'h00);
	assign eow   = zero || end_q;
	assign mode  = (c_now[2:1] == MODE_SYNC) ? MODE_FREE : c_now[2:1];
	assign pmode = ctrl_b[2:1];
	assign diff  = $signed({1'b0, ram_rd}) - 9'sd128;
	assign prod  = diff * $signed({1'b0, bank_a[BANK_VOL]});

	always_comb begin
		c2   = c_now;
		acc2 = acc_new_q;
		if (eow) begin
			if (mode != MODE_FREE || zero) c2[0] = 1'b1;
			else acc2 = acc2 - wrap_q;
			if (mode != MODE_SWAP && pmode == MODE_SWAP && !osc_q[0]) begin
				c2[0] = 1'b0;
				acc2  = acc2 - wrap_q;
			end
		end
	end

	// ---- interrupt status search ----
	logic [NUM_OSC-1:0] en_m, m, low;
	logic [OSC_W-1:0]   enc;
	logic [7:0]         irq_v, rd_val;
	always_comb begin
		for (int i = 0; i < NUM_OSC; i++) en_m[i] = (CNT_W'(i) < n_now);
		m   = pend_q & en_m;
		low = m & (~m + NUM_OSC'(1));
		enc = '0;
		for (int i = 0; i < NUM_OSC; i++) begin
			if (low[i]) enc = enc | OSC_W'(i);
		end
		irq_v = 8'({enc, 1'b0});
		if (addr_q == ADDR_IRQ) begin
			rd_val = (|m) ? (irq_v | IRQ_ANSWER) : (last_q | IRQ_ANSWER);
		end else if (addr_q[7:5] == BANK_DATA) begin
			rd_val = lfb_rd;
		end else begin
			rd_val = bank_a[addr_q[7:5]];
		end
	end

	// ---- bank write selection ----
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			bwe[b] = 1'b0;
			bwa[b] = osc_q;
			bwd[b] = val_q;
			if (op == OP_CLR) begin
				bwe[b] = 1'b1;
				bwa[b] = clr_q[OSC_W-1:0];
				bwd[b] = (3'(b) == BANK_CTRL) ? 8'h01 : 8'h00;
			end else if (op == OP_WR && addr_q[7:5] == 3'(b)) begin
				bwe[b] = 1'b1;
				bwa[b] = addr_q[OSC_W-1:0];
			end else if (op == OP_TMX && 3'(b) == BANK_CTRL) begin
				bwe[b] = 1'b1;
				bwd[b] = c2;
			end else if (op == OP_TPW && 3'(b) == BANK_CTRL) begin
				bwe[b] = 1'b1;
				bwa[b] = part;
				bwd[b] = ctrl_b & 8'hFE;
			end
		end
	end

	// ---- register banks, one memory each but the data bank ----
	for (genvar b = 0; b < 8; b++) begin : g_bank
		if (b == BANK_DATA) begin : g_none
			assign bank_a[b] = 8'h00;
		end else begin : g_mem
			logic [7:0] mem [NUM_OSC];
			always_ff @(posedge clk) begin
				if (bwe[b]) mem[bwa[b]] <= bwd[b];
				bank_a[b] <= mem[rd_addr];
			end
			if (b == BANK_CTRL) begin : g_pb
				always_ff @(posedge clk) ctrl_b <= mem[rd_addr ^ OSC_W'(1)];
			end else if (b == BANK_MISC) begin : g_pb
				always_ff @(posedge clk) misc_b <= mem[rd_addr ^ OSC_W'(1)];
			end
		end
	end

	// ---- accumulator memory ----
	always_comb begin
		awe = 1'b0;
		awa = osc_q;
		awd = '0;
		case (op)
			OP_CLR: begin
				awe = 1'b1;
				awa = clr_q[OSC_W-1:0];
			end
			OP_WR: begin
				awa = addr_q[OSC_W-1:0];
				awe = (addr_q[7:5] == BANK_CTRL) && bank_a[BANK_CTRL][0] && !val_q[0];
			end
			OP_TMX: begin
				awe = 1'b1;
				awd = acc2;
			end
			OP_TPW: begin
				awe = 1'b1;
				awa = part;
			end
			default: awe = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (awe) acc_mem[awa] <= awd;
		acc_rd <= acc_mem[rd_addr];
	end

	// ---- last fetched bytes ----
	always_ff @(posedge clk) begin
		if (op == OP_CLR) lfb_mem[clr_q[OSC_W-1:0]] <= SILENCE;
		else if (op == OP_TMX) lfb_mem[osc_q] <= ram_rd;
		lfb_rd <= lfb_mem[rd_addr];
	end

	// ---- sound RAM ----
	always_ff @(posedge clk) begin
		if (op == OP_CLR) ram_mem[clr_q] <= 8'h00;
		else if (op == OP_CAP && req_type == REQ_RAM) ram_mem[ram_addr[RAM_AW-1:0]] <= ram_data;
		if (op == OP_TAD) ram_rd <= ram_mem[faddr];
	end

	// ---- item capture and mix ----
	logic signed [27:0] scaled;
	logic signed [20:0] q;
	logic signed [15:0] res_sample_q;
	logic [7:0]         res_rd_q;
	assign scaled = mix_q * $signed({2'b00, mv_q} + 6'sd1);
	assign q      = 21'(scaled >>> 7);

	always_ff @(posedge clk) begin
		if (op == OP_CAP) begin
			addr_q       <= reg_addr;
			val_q        <= reg_value;
			res_sample_q <= '0;
			res_rd_q     <= '0;
		end
		if (op == OP_TN) mix_q <= '0;
		if (op == OP_TMX && !zero) mix_q <= mix_q + 22'(prod);
		if (op == OP_TFIN) begin
			if (q > 21'sd32767) res_sample_q <= 16'sh7FFF;
			else if (q < -21'sd32768) res_sample_q <= 16'sh8000;
			else res_sample_q <= q[15:0];
		end
		if (op == OP_RD) res_rd_q <= rd_val;
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			mv_q      <= '0;
			osc_q     <= '0;
			n_q       <= '0;
			pend_q    <= '0;
			last_q    <= 8'hFF;
			out_valid <= 1'b0;
		end else begin
			if (op == OP_CLR) clr_q <= clr_q + RAM_AW'(1);
			if (cfg_we) mv_q <= cfg_wdata;
			if (op == OP_TN) begin
				osc_q <= '0;
				n_q   <= n_now;
			end else if (cmd.adv) begin
				osc_q <= osc_q + OSC_W'(1);
			end
			if (op == OP_TMX && eow && c2[3]) pend_q[osc_q] <= 1'b1;
			if (op == OP_RD && addr_q == ADDR_IRQ && (|m)) begin
				pend_q <= pend_q & ~low;
				last_q <= irq_v | IRQ_MARK;
			end
			if (op == OP_FIN && stat.out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk) begin
		if (op == OP_FIN && stat.out_free) begin
			sample      <= res_sample_q;
			read_data   <= res_rd_q;
			irq_pending <= |pend_q;
		end
	end

	assign stat.clr_done = (clr_q == {RAM_AW{1'b1}});
	assign stat.halted   = c_now[0];
	assign stat.osc_last = ({1'b0, osc_q} == n_q - CNT_W'(1));
	assign stat.swap     = eow && (mode == MODE_SWAP);
	assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/wavetable_oscillator_bank.sv =====
// ---------------------------------------------------------------------------
// wavetable_oscillator_bank
// Wavetable oscillator bank: sequencer plus datapath.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one request beat: a sample tick,
// a chip register write, a chip register read or a sound RAM write. Every
// request gives exactly one result beat on the output channel
// (out_valid/out_ready) with sample, read_data and irq_pending.
// The single read port of the sound RAM means a tick works through the
// active oscillators one by one: each is read, fetched and written back.
// One request is in work at a time; in_ready is high only when idle.
// After reset the block sweeps the sound RAM, register banks, accumulators
// and data bytes to their reset values, with in_ready low;
// master volume writes (cfg_we) are taken throughout.
// A result waits in the output register while the receiver stalls; the
// next request is accepted meanwhile and its result waits until free.
// ---------------------------------------------------------------------------
module wavetable_oscillator_bank import wob_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [7:0]         reg_addr,
	input  logic [7:0]         reg_value,
	input  logic [15:0]        ram_addr,
	input  logic [7:0]         ram_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic [7:0]         read_data,
	output logic               irq_pending
);

	wob_cmd_t  cmd;
	wob_stat_t stat;

	// sequencer
	wob_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and arithmetic
	wob_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.reg_addr    (reg_addr),
		.reg_value   (reg_value),
		.ram_addr    (ram_addr),
		.ram_data    (ram_data),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample),
		.read_data   (read_data),
		.irq_pending (irq_pending)
	);

endmodule

// ===== rtl/wob_checker.sv =====
// ---------------------------------------------------------------------------
// wob_props
// Port-level checks of the oscillator bank, bound to the top level.
// ---------------------------------------------------------------------------
`include "wavetable_oscillator_bank_defines.svh"

module wob_props (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [15:0] sample,
	input logic [7:0]        read_data,
	input logic              irq_pending
);

	// a result carries either a sample or read data, never both
	`WOB_ASSERT_NOW(a_one_payload, out_valid && sample != 16'sd0, read_data == 8'h00)

	// one request in work at a time: busy right after an accept
	`WOB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a stalled result holds
	`WOB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(sample) && $stable(read_data) && $stable(irq_pending))

endmodule

bind wavetable_oscillator_bank wob_props u_wob_props (.*);

// ===== sim/wob_checker.sv =====
// ---------------------------------------------------------------------------
// wob_checker
// Watches both channels and the volume port of the oscillator bank, keeps
// its own copy of registers, accumulators and sound RAM, predicts each
// result beat and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module wob_checker import wob_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [7:0]         reg_addr,
	input  logic [7:0]         reg_value,
	input  logic [15:0]        ram_addr,
	input  logic [7:0]         ram_data,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample,
	input  logic [7:0]         read_data,
	input  logic               irq_pending,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] smp;
		logic [7:0]         rd;
		logic               irq;
	} wob_result_t;

	logic [7:0]  chip_regs [256];
	logic [31:0] phase [32];
	logic [7:0]  fetched [32];
	logic [7:0]  snd_ram [65536];
	logic [31:0] irq_bits;
	logic [7:0]  irq_last;
	logic [3:0]  gain;
	wob_result_t pending_results [$];

	function automatic void clear_model();
		for (int i = 0; i < 256; i++) chip_regs[i] = 8'h00;
		for (int i = 0; i < 32; i++) begin
			chip_regs[8'hA0 + i] = 8'h01;
			phase[i] = 32'h0;
			fetched[i] = SILENCE;
		end
		for (int i = 0; i < 65536; i++) snd_ram[i] = 8'h00;
		irq_bits = 32'h0;
		irq_last = 8'hFF;
		gain = 4'h0;
	endfunction

	function automatic int osc_count();
		return int'(chip_regs[8'hE1][5:1]) + 1;
	endfunction

	function automatic logic [31:0] wrap_span(int o, int sh);
		logic [2:0] sz;
		sz = chip_regs[8'hC0 + o][5:3];
		return ((32'd256 << sz) - 32'd1) << sh;
	endfunction

	// apply the halt / loop / swap rules at the end of a table
	function automatic void wave_end(int o, bit zero_byte, inout logic [31:0] acc, input int sh);
		int         p;
		logic [7:0] c;
		logic [1:0] mode;
		logic [1:0] pmode;
		p = o ^ 1;
		c = chip_regs[8'hA0 + o];
		mode = c[2:1];
		pmode = chip_regs[8'hA0 + p][2:1];
		if (mode == MODE_SYNC) mode = MODE_FREE;
		if (mode != MODE_FREE || zero_byte) c[0] = 1'b1;
		else acc -= wrap_span(o, sh);
		if (mode == MODE_SWAP) begin
			chip_regs[8'hA0 + p][0] = 1'b0;
			phase[p] = 32'h0;
		end else if (pmode == MODE_SWAP && (o & 1) == 0) begin
			c[0] = 1'b0;
			acc -= wrap_span(o, sh);
		end
		chip_regs[8'hA0 + o] = c;
		if (c[3]) irq_bits[o] = 1'b1;
	endfunction

	// run every active oscillator once and return the raw mix
	function automatic int tick_mix();
		int          n;
		int          mix;
		int          sh;
		logic [7:0]  c;
		logic [7:0]  w;
		logic [2:0]  sz;
		logic [16:0] base;
		logic [31:0] acc;
		logic [31:0] pos;
		logic [31:0] idx;
		logic [16:0] addr;
		logic [7:0]  raw;
		n = osc_count();
		mix = 0;
		for (int o = 0; o < n; o++) begin
			c = chip_regs[8'hA0 + o];
			w = chip_regs[8'hC0 + o];
			if (!c[0]) begin
				sz = w[5:3];
				sh = 9 + int'(w[2:0]) - int'(sz);
				base = {1'b0, chip_regs[8'h80 + o], 8'h00} & (17'h1FF00 << sz);
				acc = phase[o];
				pos = acc >> sh;
				idx = pos & ((32'd256 << sz) - 32'd1);
				acc += {16'h0, chip_regs[8'h20 + o], chip_regs[o]};
				addr = idx[16:0] + base;
				raw = snd_ram[addr[15:0]];
				fetched[o] = raw;
				if (raw == 8'h00) begin
					wave_end(o, 1'b1, acc, sh);
				end else begin
					mix += (int'(raw) - 128) * int'(chip_regs[8'h40 + o]);
					if (pos >= (32'd256 << sz) - 32'd1) wave_end(o, 1'b0, acc, sh);
				end
				phase[o] = acc;
			end
		end
		return mix;
	endfunction

	function automatic logic signed [15:0] scaled(int mix);
		int q;
		q = (mix * (int'(gain) + 1)) >>> 7;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function automatic logic [7:0] chip_read(logic [7:0] r);
		logic [7:0] v;
		int         n;
		if (r == ADDR_IRQ) begin
			v = irq_last;
			n = osc_count();
			for (int i = 0; i < n; i++) begin
				if (irq_bits[i]) begin
					v = 8'(i << 1);
					irq_last = v | IRQ_MARK;
					irq_bits[i] = 1'b0;
					break;
				end
			end
			return v | IRQ_ANSWER;
		end
		if (r >= 8'h60 && r <= 8'h7F) return fetched[r - 8'h60];
		return chip_regs[r];
	endfunction

	function automatic void chip_write(logic [7:0] r, logic [7:0] v);
		// key-on zeroes the accumulator
		if (r >= 8'hA0 && r <= 8'hBF && chip_regs[r][0] && !v[0]) phase[r - 8'hA0] = 32'h0;
		chip_regs[r] = v;
	endfunction

	function automatic wob_result_t predict_beat();
		wob_result_t e;
		e.smp = '0;
		e.rd = '0;
		case (req_type)
			REQ_TICK:  e.smp = scaled(tick_mix());
			REQ_WRITE: chip_write(reg_addr, reg_value);
			REQ_READ:  e.rd = chip_read(reg_addr);
			default:   snd_ram[ram_addr] = ram_data;
		endcase
		e.irq = (irq_bits != 0);
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wob_result_t e;
		if (!arst_n) begin
			clear_model();
			pending_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) gain = cfg_wdata;
			// compare the result beat with the oldest prediction
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result beat: sample %0d read_data %h irq %b",
							sample, read_data, irq_pending);
					mismatches <= mismatches + 1;
				end else begin
					e = pending_results.pop_front();
					if (e.smp !== sample || e.rd !== read_data || e.irq !== irq_pending) begin
						if (mismatches < 10)
							$display("mismatch: exp sample %0d rd %h irq %b, got %0d %h %b",
								e.smp, e.rd, e.irq, sample, read_data, irq_pending);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (in_valid && in_ready) pending_results.push_back(predict_beat());
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== sim/tb_wavetable_oscillator_bank.sv =====
// ---------------------------------------------------------------------------
// tb_wavetable_oscillator_bank
// Drives ticks, register traffic and sound RAM writes into the oscillator
// bank in bursts, stalls the result side, and reports the checker verdict.
// ---------------------------------------------------------------------------
module tb_wavetable_oscillator_bank import wob_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = REQ_TICK;
	logic [7:0]         reg_addr = '0;
	logic [7:0]         reg_value = '0;
	logic [15:0]        ram_addr = '0;
	logic [7:0]         ram_data = '0;
	logic               cfg_we = 1'b0;
	logic [3:0]         cfg_wdata = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] sample;
	logic [7:0]         read_data;
	logic               irq_pending;
	int                 mismatches;
	int                 outstanding;

	int n_items = 0;
	int burst_left = 4;
	bit hold_req = 0;
	int hold_cnt = 0;
	int rx_mode = 0;
	int rx_left = 0;

	always #6 clk = ~clk;

	wavetable_oscillator_bank i_dut (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .reg_addr, .reg_value,
		.ram_addr, .ram_data, .cfg_we, .cfg_wdata, .out_valid, .out_ready,
		.sample, .read_data, .irq_pending
	);

	wob_checker i_checker (
		.clk, .arst_n, .in_valid, .in_ready, .req_type, .reg_addr, .reg_value,
		.ram_addr, .ram_data, .cfg_we, .cfg_wdata, .out_valid, .out_ready,
		.sample, .read_data, .irq_pending, .mismatches, .outstanding
	);

	// receiver: long hold-off on request, else switch among stall patterns
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// offer one beat, hold it until accepted, then maybe open a gap
	task automatic push_req(input logic [1:0] t, input logic [7:0] a, input logic [7:0] v,
		input logic [15:0] ra, input logic [7:0] rd);
		in_valid <= 1'b1;
		req_type <= t;
		reg_addr <= a;
		reg_value <= v;
		ram_addr <= ra;
		ram_data <= rd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_items++;
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
	endtask

	task automatic reg_wr(input logic [7:0] a, input logic [7:0] v);
		push_req(REQ_WRITE, a, v, 16'($urandom), 8'($urandom));
	endtask

	task automatic reg_rd(input logic [7:0] a);
		push_req(REQ_READ, a, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	task automatic ram_wr(input logic [15:0] ra, input logic [7:0] rd);
		push_req(REQ_RAM, 8'($urandom), 8'($urandom), ra, rd);
	endtask

	task automatic tick();
		push_req(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// stop offering and wait for every predicted beat
	task automatic drain();
		if (in_valid) in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_gain(input logic [3:0] g);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] osc_reg(input logic [2:0] bank, input int o);
		return {bank, 5'(o)};
	endfunction

	// one well-formed voice setup followed by ticks, reads and sound RAM writes
	task automatic voice_scenario();
		int         nosc;
		int         r;
		logic [2:0] sz;
		logic [7:0] ctl;
		nosc = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 32) : $urandom_range(1, 4);
		reg_wr(8'hE1, 8'($urandom & 8'hC1) | 8'((nosc - 1) << 1));
		for (int o = 0; o < nosc && o < 4; o++) begin
			sz = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
			reg_wr(osc_reg(BANK_FLO, o), 8'($urandom));
			reg_wr(osc_reg(BANK_FHI, o),
				($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h40, 8'hFF)));
			reg_wr(osc_reg(BANK_VOL, o), 8'($urandom));
			reg_wr(osc_reg(BANK_PTR, o), ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h20);
			reg_wr(osc_reg(BANK_WAVE, o), {2'($urandom), sz, 3'($urandom)});
			ctl = 8'($urandom & 8'hF0) | 8'($urandom_range(0, 1) << 3)
				| 8'($urandom_range(0, 3) << 1);
			if ($urandom_range(0, 9) == 0) ctl[0] = 1'b1;
			reg_wr(osc_reg(BANK_CTRL, o), ctl);
		end
		repeat ($urandom_range(4, 16)) begin
			r = $urandom_range(0, 9);
			if (r <= 6) tick();
			else if (r == 7) reg_rd(ADDR_IRQ);
			else if (r == 8) reg_rd(8'($urandom));
			else ram_wr(16'h2000 | 16'($urandom_range(0, 16'h1FF)), 8'($urandom));
		end
	endtask

	// unstructured traffic on every field
	task automatic noise_scenario();
		repeat ($urandom_range(3, 10))
			push_req(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	initial begin
		int scen;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_gain(4'hF);

		// directed: field extremes, irq paths, swap partner, full oscillator count
		ram_wr(16'h0000, 8'hFF);
		ram_wr(16'hFFFF, 8'h00);
		ram_wr(16'h3000, 8'hFF);
		ram_wr(16'h3001, 8'h01);
		ram_wr(16'h3080, 8'h00);
		reg_wr(8'hE1, 8'h02);
		reg_wr(osc_reg(BANK_FLO, 0), 8'hFF);
		reg_wr(osc_reg(BANK_FHI, 0), 8'hFF);
		reg_wr(osc_reg(BANK_VOL, 0), 8'hFF);
		reg_wr(osc_reg(BANK_PTR, 0), 8'h30);
		reg_wr(osc_reg(BANK_WAVE, 0), 8'h00);
		reg_wr(osc_reg(BANK_CTRL, 0), 8'h08);
		reg_wr(osc_reg(BANK_CTRL, 1), 8'h07);
		repeat (4) tick();
		reg_rd(ADDR_IRQ);
		reg_rd(ADDR_IRQ);
		reg_rd(osc_reg(BANK_DATA, 0));
		reg_rd(osc_reg(BANK_CTRL, 0));
		reg_wr(ADDR_IRQ, 8'hFF);
		reg_rd(8'hE1);
		reg_wr(osc_reg(BANK_CTRL, 1), 8'h0E);
		repeat (3) tick();
		reg_wr(8'hE1, 8'hFF);
		tick();
		reg_rd(ADDR_IRQ);

		drain();
		set_gain(4'h0);
		// fill one table page with mostly nonzero samples
		for (int i = 0; i < 256; i++)
			ram_wr(16'h2000 | 16'(i), (i % 61 == 60) ? 8'h00 : 8'($urandom_range(1, 255)));

		scen = 0;
		while (n_items < 1350) begin
			scen++;
			if (scen % 8 == 0) begin
				drain();
				case ((scen / 8) % 3)
					0: set_gain(4'h0);
					1: set_gain(4'hF);
					default: set_gain(4'($urandom));
				endcase
			end
			if (scen == 5) hold_req = 1;
			if ($urandom_range(0, 99) < 85) voice_scenario();
			else noise_scenario();
		end

		drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog: reset sweep plus a generous margin
	initial begin
		#12ms;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wob_pkg.sv
rtl/wob_ctrl.sv
rtl/wob_datapath.sv
rtl/wavetable_oscillator_bank.sv
rtl/wob_checker.sv
sim/wob_checker.sv
sim/tb_wavetable_oscillator_bank.sv
